>>> rtl/core/matrix_to_quaternion_shepperd_unit_assert.svh
// Assertion macros for the matrix to quaternion unit.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef MATRIX_TO_QUATERNION_SHEPPERD_UNIT_ASSERT_SVH
`define MATRIX_TO_QUATERNION_SHEPPERD_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define MQS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// A stalled item keeps valid high and its payload unchanged.
`define MQS_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
	`MQS_ASSERT(lbl, (vld) && !(rdy) |=> (vld) && $stable(data), msg)

`endif

>>> rtl/core/mqs_pkg.sv
// Package for the matrix to quaternion unit: payload types, cell control and constants.
// Depends on nothing.
package mqs_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int NQ = 4;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic               invalid;
	} quat_t;

	typedef struct packed {
		logic en;
		logic vld;
	} stg_ctl_t;

endpackage

>>> rtl/core/mqs_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per item and passes it on.
// Depends on mqs_pkg.
module mqs_sqrt_cell #(
	parameter int NW = 40,
	parameter int RW = 20,
	parameter int PW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mqs_pkg::stg_ctl_t   ctl,
	input  logic [RW:0]         rem_i,
	input  logic [RW-1:0]       root_i,
	input  logic [NW-1:0]       nrm_i,
	input  logic [PW-1:0]       side_i,
	output logic                vld_o,
	output logic [RW:0]         rem_o,
	output logic [RW-1:0]       root_o,
	output logic [NW-1:0]       nrm_o,
	output logic [PW-1:0]       side_o
);
	import mqs_pkg::*;

	logic [RW+2:0] cur;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;
	logic          ge;
	logic          vld_q;
	logic [RW:0]   rem_q;
	logic [RW-1:0] root_q;
	logic [NW-1:0] nrm_q;
	logic [PW-1:0] side_q;

	always_comb begin
		cur   = {rem_i, nrm_i[NW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rem_q  <= ge ? diff[RW:0] : cur[RW:0];
			root_q <= {root_i[RW-2:0], ge};
			nrm_q  <= {nrm_i[NW-3:0], 2'b00};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign nrm_o  = nrm_q;
	assign side_o = side_q;

endmodule

>>> rtl/core/mqs_div_cell.sv
// One cell of the divider chain: settles one quotient bit in each of the four lanes.
// Depends on mqs_pkg.
module mqs_div_cell #(
	parameter int DW = 21,
	parameter int QW = 15,
	parameter int PW = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mqs_pkg::stg_ctl_t                  ctl,
	input  logic [DW-1:0]                      d_i,
	input  logic [mqs_pkg::NQ-1:0][DW-1:0]     rem_i,
	input  logic [mqs_pkg::NQ-1:0][QW-1:0]     low_i,
	input  logic [mqs_pkg::NQ-1:0][QW-1:0]     quo_i,
	input  logic [PW-1:0]                      side_i,
	output logic                               vld_o,
	output logic [DW-1:0]                      d_o,
	output logic [mqs_pkg::NQ-1:0][DW-1:0]     rem_o,
	output logic [mqs_pkg::NQ-1:0][QW-1:0]     low_o,
	output logic [mqs_pkg::NQ-1:0][QW-1:0]     quo_o,
	output logic [PW-1:0]                      side_o
);
	import mqs_pkg::*;

	logic [NQ-1:0][DW:0]   cur;
	logic [NQ-1:0][DW:0]   diff;
	logic [NQ-1:0]         ge;
	logic                  vld_q;
	logic [DW-1:0]         d_q;
	logic [NQ-1:0][DW-1:0] rem_q;
	logic [NQ-1:0][QW-1:0] low_q;
	logic [NQ-1:0][QW-1:0] quo_q;
	logic [PW-1:0]         side_q;

	always_comb begin
		for (int k = 0; k < NQ; k++) begin
			cur[k]  = {rem_i[k], low_i[k][QW-1]};
			diff[k] = cur[k] - {1'b0, d_i};
			ge[k]   = (cur[k] >= {1'b0, d_i});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			d_q    <= d_i;
			side_q <= side_i;
			for (int k = 0; k < NQ; k++) begin
				rem_q[k] <= ge[k] ? diff[k][DW-1:0] : cur[k][DW-1:0];
				low_q[k] <= {low_i[k][QW-2:0], 1'b0};
				quo_q[k] <= {quo_i[k][QW-2:0], ge[k]};
			end
		end
	end

	assign vld_o  = vld_q;
	assign d_o    = d_q;
	assign rem_o  = rem_q;
	assign low_o  = low_q;
	assign quo_o  = quo_q;
	assign side_o = side_q;

endmodule

>>> rtl/core/matrix_to_quaternion_shepperd_unit.sv
// Top level of the rotation matrix to unit quaternion converter (Shepperd's method).
// Depends on mqs_pkg, mqs_sqrt_cell and mqs_div_cell.
//
// Channel   Handshake                 Payload
// input     in_valid / in_ready       in_data  (mqs_pkg::mat_t)
// output    out_valid / out_ready     out_data (mqs_pkg::quat_t)
//
// One item is accepted per cycle while the output side keeps taking results.
// The pipeline runs through stages s1, s2 and s3, the square-root chain of RW cells,
// the divider chain of FRAC_BITS + 1 cells and an output register; RW = max(FRAC_BITS, 17) + 3.
// Reset clears the valid bits only; the datapath registers hold no reset.
// When a result waits untaken, the whole pipeline holds and in_ready falls.
module matrix_to_quaternion_shepperd_unit #(
	parameter int FRAC_BITS = mqs_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mqs_pkg::mat_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mqs_pkg::quat_t out_data
);
	import mqs_pkg::*;

	localparam int VW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
	localparam int MW   = VW - 1;
	localparam int NW   = 2 * VW;
	localparam int RW   = VW;
	localparam int QW   = FRAC_BITS + 1;
	localparam int DW   = RW + 1;
	localparam int PWS  = NQ * MW + NQ + 1;
	localparam int PWD  = NQ + 1;
	localparam int PKW  = ((QW > 17) ? QW : 17) + 1;
	localparam logic [PKW-1:0] ONE_E  = PKW'(1) << FRAC_BITS;
	localparam logic [PKW-1:0] SMAX   = PKW'(32767);
	localparam logic [PKW-1:0] SMINM  = PKW'(32768);
	localparam logic [PKW-1:0] ID_E   = (ONE_E > SMAX) ? SMAX : ONE_E;
	localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

	logic en;
	logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr, rad;
	logic signed [VW-1:0] v_n [NQ];

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [VW-1:0] v_s1 [NQ];
	logic                 radpos_s1, radpos_s2, radpos_s3;
	logic [NQ-1:0][MW-1:0] mag_s2, mag_s3;
	logic [NQ-1:0]        sgn_s2, sgn_s3;
	logic [2*MW-1:0]      sq_s2 [NQ];
	logic [NW-1:0]        nsq_s3;

	logic [RW:0]    s_rem  [RW+1];
	logic [RW-1:0]  s_root [RW+1];
	logic [NW-1:0]  s_nrm  [RW+1];
	logic [PWS-1:0] s_side [RW+1];
	logic           s_vld  [RW+1];

	logic [DW-1:0]         d_d    [QW+1];
	logic [NQ-1:0][DW-1:0] d_rem  [QW+1];
	logic [NQ-1:0][QW-1:0] d_low  [QW+1];
	logic [NQ-1:0][QW-1:0] d_quo  [QW+1];
	logic [PWD-1:0]        d_side [QW+1];
	logic                  d_vld  [QW+1];

	logic [RW-1:0]         n_root;
	logic [NQ-1:0][MW-1:0] n_mag;
	logic [NQ-1:0]         n_sgn;
	logic                  n_inv;
	logic [15:0]           qo [NQ];
	logic [PKW-1:0]        qe [NQ];
	logic [PKW-1:0]        qp [NQ];
	logic [PKW-1:0]        qn [NQ];

	logic  out_vld_q;
	quat_t out_q;

	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	always_comb begin
		e00 = VW'(in_data.r00);
		e01 = VW'(in_data.r01);
		e02 = VW'(in_data.r02);
		e10 = VW'(in_data.r10);
		e11 = VW'(in_data.r11);
		e12 = VW'(in_data.r12);
		e20 = VW'(in_data.r20);
		e21 = VW'(in_data.r21);
		e22 = VW'(in_data.r22);
		tr  = e00 + e11 + e22;
		if (tr > 0) begin
			rad    = ONE_V + tr;
			v_n[0] = e21 - e12;
			v_n[1] = e02 - e20;
			v_n[2] = e10 - e01;
			v_n[3] = rad;
		end else if (e00 > e11 && e00 > e22) begin
			rad    = ONE_V + e00 - e11 - e22;
			v_n[0] = rad;
			v_n[1] = e01 + e10;
			v_n[2] = e02 + e20;
			v_n[3] = e21 - e12;
		end else if (e11 > e22) begin
			rad    = ONE_V + e11 - e00 - e22;
			v_n[0] = e01 + e10;
			v_n[1] = rad;
			v_n[2] = e12 + e21;
			v_n[3] = e02 - e20;
		end else begin
			rad    = ONE_V + e22 - e00 - e11;
			v_n[0] = e02 + e20;
			v_n[1] = e12 + e21;
			v_n[2] = rad;
			v_n[3] = e10 - e01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			radpos_s1 <= (rad > 0);
			for (int k = 0; k < NQ; k++) begin
				v_s1[k] <= v_n[k];
			end
			radpos_s2 <= radpos_s1;
			for (int k = 0; k < NQ; k++) begin
				sgn_s2[k] <= v_s1[k][VW-1];
				mag_s2[k] <= v_s1[k][VW-1] ? MW'(-v_s1[k]) : v_s1[k][MW-1:0];
				sq_s2[k]  <= (v_s1[k][VW-1] ? MW'(-v_s1[k]) : v_s1[k][MW-1:0])
					* (v_s1[k][VW-1] ? MW'(-v_s1[k]) : v_s1[k][MW-1:0]);
			end
			radpos_s3 <= radpos_s2;
			sgn_s3    <= sgn_s2;
			mag_s3    <= mag_s2;
			nsq_s3    <= NW'(sq_s2[0]) + NW'(sq_s2[1]) + NW'(sq_s2[2]) + NW'(sq_s2[3]);
		end
	end

	assign s_rem[0]  = '0;
	assign s_root[0] = '0;
	assign s_nrm[0]  = nsq_s3;
	assign s_side[0] = {radpos_s3, sgn_s3, mag_s3};
	assign s_vld[0]  = vld_s3;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		mqs_sqrt_cell #(
			.NW(NW),
			.RW(RW),
			.PW(PWS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   ('{en: en, vld: s_vld[g]}),
			.rem_i (s_rem[g]),
			.root_i(s_root[g]),
			.nrm_i (s_nrm[g]),
			.side_i(s_side[g]),
			.vld_o (s_vld[g+1]),
			.rem_o (s_rem[g+1]),
			.root_o(s_root[g+1]),
			.nrm_o (s_nrm[g+1]),
			.side_o(s_side[g+1])
		);
	end

	always_comb begin
		n_root = s_root[RW];
		n_mag  = s_side[RW][NQ*MW-1:0];
		n_sgn  = s_side[RW][NQ*MW +: NQ];
		n_inv  = !s_side[RW][PWS-1] || (n_root == '0);
		d_d[0] = {n_root, 1'b0};
		for (int k = 0; k < NQ; k++) begin
			d_rem[0][k] = DW'(n_mag[k]) + DW'(n_root[RW-1:QW]);
			d_low[0][k] = n_root[QW-1:0];
			d_quo[0][k] = '0;
		end
		d_side[0] = {n_inv, n_sgn};
		d_vld[0]  = s_vld[RW];
	end

	for (genvar g = 0; g < QW; g++) begin : g_div
		mqs_div_cell #(
			.DW(DW),
			.QW(QW),
			.PW(PWD)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   ('{en: en, vld: d_vld[g]}),
			.d_i   (d_d[g]),
			.rem_i (d_rem[g]),
			.low_i (d_low[g]),
			.quo_i (d_quo[g]),
			.side_i(d_side[g]),
			.vld_o (d_vld[g+1]),
			.d_o   (d_d[g+1]),
			.rem_o (d_rem[g+1]),
			.low_o (d_low[g+1]),
			.quo_o (d_quo[g+1]),
			.side_o(d_side[g+1])
		);
	end

	always_comb begin
		for (int k = 0; k < NQ; k++) begin
			qe[k] = PKW'(d_quo[QW][k]);
			if (qe[k] > ONE_E) begin
				qe[k] = ONE_E;
			end
			qp[k] = (qe[k] > SMAX) ? SMAX : qe[k];
			qn[k] = (qe[k] > SMINM) ? SMINM : qe[k];
			qo[k] = d_side[QW][k] ? (16'd0 - qn[k][15:0]) : qp[k][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= d_vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_side[QW][NQ]) begin
				out_q.qx      <= '0;
				out_q.qy      <= '0;
				out_q.qz      <= '0;
				out_q.qw      <= ID_E[15:0];
				out_q.invalid <= 1'b1;
			end else begin
				out_q.qx      <= qo[0];
				out_q.qy      <= qo[1];
				out_q.qz      <= qo[2];
				out_q.qw      <= qo[3];
				out_q.invalid <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/mqs_checker.sv
// Port-level checks for the matrix to quaternion unit, bound to its top level.
// Depends on mqs_pkg and matrix_to_quaternion_shepperd_unit_assert.svh.
`include "matrix_to_quaternion_shepperd_unit_assert.svh"

module mqs_checker #(
	parameter int FRAC_BITS = mqs_pkg::FRAC_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input mqs_pkg::mat_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input mqs_pkg::quat_t out_data
);
	import mqs_pkg::*;

	localparam int LIM_HI = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
	localparam int LIM_LO = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);

	logic ident_ok;
	logic range_ok;

	assign ident_ok = out_data.qx == '0 && out_data.qy == '0 && out_data.qz == '0
		&& int'(out_data.qw) == LIM_HI;
	assign range_ok = int'(out_data.qw) <= LIM_HI && int'(out_data.qw) >= LIM_LO
		&& int'(out_data.qx) <= LIM_HI && int'(out_data.qx) >= LIM_LO;

	`MQS_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data, "Output item changed.")

	`MQS_ASSERT(a_free_accept, !out_valid |-> in_ready, "Input refused with output empty.")

	`MQS_ASSERT(a_invalid_id, out_valid && out_data.invalid |-> ident_ok, "Invalid not identity.")

	`MQS_ASSERT(a_range, out_valid |-> range_ok, "Quaternion component out of range.")

endmodule

bind matrix_to_quaternion_shepperd_unit mqs_checker #(.FRAC_BITS(FRAC_BITS)) u_mqs_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the matrix to quaternion unit (Shepperd's method).
// Depends on mqs_pkg and matrix_to_quaternion_shepperd_unit; predicts each quaternion in a class.
`timescale 1ns / 100ps

class quat_scoreboard;
	mqs_pkg::quat_t pending[$];
	int mismatches;

	function longint root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function logic [15:0] scaled_comp(longint v, longint n);
		longint unsigned mag, q;
		longint r;
		mag = v < 0 ? -v : v;
		q = ((mag << 14) * 2 + n) / (2 * n);
		if (q > 16384)
			q = 16384;
		r = v < 0 ? -longint'(q) : longint'(q);
		return r[15:0];
	endfunction

	function mqs_pkg::quat_t shepperd(mqs_pkg::mat_t m);
		mqs_pkg::quat_t q;
		longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, n;
		longint v[4];
		longint unsigned n2, mg;
		a00 = m.r00; a01 = m.r01; a02 = m.r02;
		a10 = m.r10; a11 = m.r11; a12 = m.r12;
		a20 = m.r20; a21 = m.r21; a22 = m.r22;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			rad = 16384 + tr;
			v = '{a21 - a12, a02 - a20, a10 - a01, rad};
		end else if (a00 > a11 && a00 > a22) begin
			rad = 16384 + a00 - a11 - a22;
			v = '{rad, a01 + a10, a02 + a20, a21 - a12};
		end else if (a11 > a22) begin
			rad = 16384 + a11 - a00 - a22;
			v = '{a01 + a10, rad, a12 + a21, a02 - a20};
		end else begin
			rad = 16384 + a22 - a00 - a11;
			v = '{a02 + a20, a12 + a21, rad, a10 - a01};
		end
		n2 = 0;
		if (rad > 0)
			foreach (v[i]) begin
				mg = v[i] < 0 ? -v[i] : v[i];
				n2 += mg * mg;
			end
		n = root_floor(n2);
		if (rad <= 0 || n == 0) begin
			q = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, invalid: 1'b1};
		end else begin
			q.qx = scaled_comp(v[0], n);
			q.qy = scaled_comp(v[1], n);
			q.qz = scaled_comp(v[2], n);
			q.qw = scaled_comp(v[3], n);
			q.invalid = 1'b0;
		end
		return q;
	endfunction

	function void note_matrix(mqs_pkg::mat_t m);
		pending.push_back(shepperd(m));
	endfunction

	function void check_quat(mqs_pkg::quat_t got);
		mqs_pkg::quat_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz ||
		    got.qw !== want.qw || got.invalid !== want.invalid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch: expected %0d %0d %0d %0d inv %0b, got %0d %0d %0d %0d inv %0b",
					want.qx, want.qy, want.qz, want.qw, want.invalid,
					got.qx, got.qy, got.qz, got.qw, got.invalid);
		end
	endfunction
endclass

module tb;
	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready;
	mqs_pkg::mat_t in_data;
	mqs_pkg::quat_t out_data;
	quat_scoreboard board;
	int send_idle, recv_stall, hold_off, quiet;
	logic senders_done;

	matrix_to_quaternion_shepperd_unit DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] entry();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'(int'($urandom_range(0, 1)) ? 0 : -1);
			3: return 16'($urandom());
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic mqs_pkg::mat_t rotation();
		mqs_pkg::mat_t m;
		real a, b, c, ca, sa, cb, sb, cc, sc;
		a = $urandom_range(0, 62831) / 10000.0;
		b = $urandom_range(0, 62831) / 10000.0;
		c = $urandom_range(0, 62831) / 10000.0;
		ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cc = $cos(c); sc = $sin(c);
		m.r00 = 16'($rtoi(16384 * ca * cb));
		m.r01 = 16'($rtoi(16384 * (ca * sb * sc - sa * cc)));
		m.r02 = 16'($rtoi(16384 * (ca * sb * cc + sa * sc)));
		m.r10 = 16'($rtoi(16384 * sa * cb));
		m.r11 = 16'($rtoi(16384 * (sa * sb * sc + ca * cc)));
		m.r12 = 16'($rtoi(16384 * (sa * sb * cc - ca * sc)));
		m.r20 = 16'($rtoi(-16384 * sb));
		m.r21 = 16'($rtoi(16384 * cb * sc));
		m.r22 = 16'($rtoi(16384 * cb * cc));
		return m;
	endfunction

	task automatic send_matrix(mqs_pkg::mat_t m);
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_matrix(m);
	endtask

	task automatic send_phase(int count, int idle, int stall);
		mqs_pkg::mat_t m;
		send_idle = idle;
		recv_stall = stall;
		repeat (count) begin
			if ($urandom_range(0, 9) < 7)
				m = rotation();
			else
				m = '{entry(), entry(), entry(), entry(), entry(), entry(), entry(), entry(),
					entry()};
			send_matrix(m);
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		senders_done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Identity, the four branches, a zero matrix, and extreme entries.
		send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
		send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
		send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
		send_matrix('0);
		send_matrix('{-16384, 16384, 16384, 16384, -16384, 16384, 16384, 16384, -16384});
		send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		send_matrix('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff});
		send_matrix('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000});
		send_matrix('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff});
		send_matrix('{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192});
		send_matrix('{-16384, 5, -7, 9, -16384, 100, -3, 2, 16384});
		send_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
		send_phase(450, 0, 0);
		// Long receiver hold-off while the sender keeps offering.
		hold_off = 300;
		send_phase(150, 0, 0);
		send_phase(400, 49, 0);
		send_phase(400, 0, 49);
		send_phase(450, 24, 24);
		in_valid <= 1'b0;
		senders_done = 1;
	end

	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else
				out_ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_quat(out_data);

	initial begin
		quiet = 0;
		wait (senders_done);
		while (board.pending.size() != 0 && quiet < 2000) begin
			@(posedge clk);
			quiet++;
		end
		repeat (100) @(posedge clk);
		if (quiet < 2000 && board.mismatches == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	int idle_cycles;
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= 5000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end
endmodule
